@@ sv/ctt_pkg.sv @@
package ctt_pkg;

    // Table geometry.
    localparam int ENTRIES     = 256;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int PTR_W       = IDX_W + 1;
    localparam int BUCKET_BITS = 8;
    localparam int HASH_BITS   = 64;
    localparam int HEADS       = 3 * (1 << BUCKET_BITS);
    localparam int HEAD_AW     = 2 + BUCKET_BITS;

    // The pointer value that marks an empty head and the end of a chain.
    localparam logic [PTR_W-1:0] NIL = PTR_W'(ENTRIES);

    // Action codes.
    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    // Protocol codes.
    localparam logic [1:0] PROTO_TCP  = 2'd0;
    localparam logic [1:0] PROTO_UDP  = 2'd1;
    localparam logic [1:0] PROTO_ICMP = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_TCP_LIMIT  = 3'd0;
    localparam logic [2:0] REG_UDP_LIMIT  = 3'd1;
    localparam logic [2:0] REG_ICMP_LIMIT = 3'd2;
    localparam logic [2:0] REG_TCP_START  = 3'd3;
    localparam logic [2:0] REG_UDP_START  = 3'd4;
    localparam logic [2:0] REG_ICMP_START = 3'd5;
    localparam logic [2:0] REG_TCP_CAP    = 3'd6;
    localparam logic [2:0] REG_UDP_CAP    = 3'd7;

    // TCP connection states.
    localparam logic [2:0] TS_SYN    = 3'd0;
    localparam logic [2:0] TS_SYNACK = 3'd1;
    localparam logic [2:0] TS_CONN   = 3'd2;
    localparam logic [2:0] TS_FIN1   = 3'd3;
    localparam logic [2:0] TS_ACK1   = 3'd4;
    localparam logic [2:0] TS_FIN2   = 3'd5;
    localparam logic [2:0] TS_CLOSED = 3'd6;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  proto;
        logic [63:0] conn_hash;
        logic [3:0]  tcp_flags;
    } in_item_t;

    typedef struct packed {
        logic       found;
        logic [2:0] tcp_state_out;
        logic       allowed;
        logic       added;
        logic       table_full;
        logic [8:0] expired_count;
    } out_item_t;

    // One table entry as held in the entry memory.
    typedef struct packed {
        logic [PTR_W-1:0]     nxt;
        logic [1:0]           proto;
        logic [HASH_BITS-1:0] hash;
        logic [2:0]           tstate;
        logic [15:0]          timeout;
        logic [15:0]          idle;
    } ent_t;

    // Commands from the controller to the datapath.
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_ACCEPT,
        CMD_SET_FULL,
        CMD_LK_HEAD,
        CMD_LK_SETCUR,
        CMD_LK_RD,
        CMD_LK_HIT,
        CMD_LK_NEXT,
        CMD_AD_INC,
        CMD_AD_HEAD,
        CMD_AD_WR,
        CMD_TK_RD,
        CMD_TK_UPD,
        CMD_TK_INC,
        CMD_UL_HEAD,
        CMD_UL_SET,
        CMD_UL_RD,
        CMD_UL_STEP,
        CMD_UL_LINK,
        CMD_UL_DROP,
        CMD_OUT_LOAD
    } ctt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] act;
        logic       proto_bad;
        logic       limit_hit;
        logic       scan_free;
        logic       scan_last;
        logic       cur_nil;
        logic       hash_match;
        logic       tk_valid;
        logic       tk_expire;
        logic       tk_last;
        logic       cur_is_vic;
        logic       clr_last;
        logic       out_free;
    } ctt_status_t;

    // Head memory address of a protocol and hash.
    function automatic logic [HEAD_AW-1:0] bucket_of(input logic [1:0] proto,
                                                     input logic [HASH_BITS-1:0] h);
        bucket_of = {proto, h[HASH_BITS-1 -: BUCKET_BITS]};
    endfunction

    // TCP flag state machine: returns {allowed, new state}.
    function automatic logic [3:0] tcp_advance(input logic [2:0] st,
                                               input logic [3:0] flags);
        logic syn;
        logic ack;
        logic fin;
        logic rst;
        logic [3:0] r;
        syn = flags[0];
        ack = flags[1];
        fin = flags[2];
        rst = flags[3];
        r = {1'b0, st};
        if (rst) begin
            r = {1'b1, TS_CLOSED};
        end else begin
            case (st)
                TS_SYN: begin
                    if (ack && syn) r = {1'b1, TS_SYNACK};
                    else r = {syn, st};
                end
                TS_SYNACK: begin
                    if (ack) r = {1'b1, TS_CONN};
                end
                TS_CONN: begin
                    if (fin && ack) r = {1'b1, TS_FIN1};
                    else r = {1'b1, st};
                end
                TS_FIN1: begin
                    if (ack) r = {1'b1, TS_ACK1};
                end
                TS_ACK1: begin
                    if (fin && ack) r = {1'b1, TS_FIN2};
                    else r = {ack, st};
                end
                TS_FIN2: begin
                    if (ack) r = {1'b1, TS_CLOSED};
                end
                TS_CLOSED: begin
                    r = {ack, st};
                end
                default: begin
                    r = {1'b0, st};
                end
            endcase
        end
        tcp_advance = r;
    endfunction

endpackage

@@ sv/connection_tracking_table.sv @@
// Firewall connection table. Each request (lookup, add or one-second tick) gives exactly one
// result. After reset the 768-entry bucket head memory is cleared one entry per cycle, so no
// request is taken until the clear is done; configuration writes are taken at any time. A
// lookup reads the bucket head and then walks the chain, with one read of the entry memory for
// each chain entry visited. An add scans the slots from the lowest up to the first free one. A
// tick visits all 256 slots and unlinks every expired entry by walking its bucket's chain. One
// request is worked at a time; a finished result waits in an output register while the next
// request is taken.
module connection_tracking_table (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ctt_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output ctt_pkg::out_item_t m_item,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wdata
);

    ctt_pkg::ctt_cmd_t    cmd;
    ctt_pkg::ctt_status_t st;

    // Sequencer.
    ctt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // Tables, registers and result path.
    ctt_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

@@ sv/ctt_ctrl.sv @@
module ctt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ctt_pkg::ctt_status_t st,
    output ctt_pkg::ctt_cmd_t    cmd
);

    typedef enum logic [17:0] {
        S_CLEAR     = 18'h00001,
        S_IDLE      = 18'h00002,
        S_DISP      = 18'h00004,
        S_AD_SCAN   = 18'h00008,
        S_AD_HEAD   = 18'h00010,
        S_AD_WR     = 18'h00020,
        S_LK_HEAD   = 18'h00040,
        S_LK_SETCUR = 18'h00080,
        S_LK_RD     = 18'h00100,
        S_LK_CMP    = 18'h00200,
        S_TK_RD     = 18'h00400,
        S_TK_UPD    = 18'h00800,
        S_TK_NEXT   = 18'h01000,
        S_UL_HEAD   = 18'h02000,
        S_UL_SET    = 18'h04000,
        S_UL_RD     = 18'h08000,
        S_UL_CMP    = 18'h10000,
        S_DONE      = 18'h20000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == S_IDLE);

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command.
    always_comb begin
        state_next = state_reg;
        cmd        = ctt_pkg::CMD_NONE;
        case (state_reg)
            S_CLEAR: begin
                cmd = ctt_pkg::CMD_CLEAR;
                if (st.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd        = ctt_pkg::CMD_ACCEPT;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                case (st.act)
                    ctt_pkg::ACT_LOOKUP: begin
                        state_next = st.proto_bad ? S_DONE : S_LK_HEAD;
                    end
                    ctt_pkg::ACT_ADD: begin
                        if (st.proto_bad) begin
                            state_next = S_DONE;
                        end else if (st.limit_hit) begin
                            cmd        = ctt_pkg::CMD_SET_FULL;
                            state_next = S_DONE;
                        end else begin
                            state_next = S_AD_SCAN;
                        end
                    end
                    ctt_pkg::ACT_TICK: begin
                        state_next = S_TK_RD;
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_AD_SCAN: begin
                if (st.scan_free) begin
                    state_next = S_AD_HEAD;
                end else if (st.scan_last) begin
                    cmd        = ctt_pkg::CMD_SET_FULL;
                    state_next = S_DONE;
                end else begin
                    cmd = ctt_pkg::CMD_AD_INC;
                end
            end
            S_AD_HEAD: begin
                cmd        = ctt_pkg::CMD_AD_HEAD;
                state_next = S_AD_WR;
            end
            S_AD_WR: begin
                cmd        = ctt_pkg::CMD_AD_WR;
                state_next = S_DONE;
            end
            S_LK_HEAD: begin
                cmd        = ctt_pkg::CMD_LK_HEAD;
                state_next = S_LK_SETCUR;
            end
            S_LK_SETCUR: begin
                cmd        = ctt_pkg::CMD_LK_SETCUR;
                state_next = S_LK_RD;
            end
            S_LK_RD: begin
                if (st.cur_nil) begin
                    state_next = S_DONE;
                end else begin
                    cmd        = ctt_pkg::CMD_LK_RD;
                    state_next = S_LK_CMP;
                end
            end
            S_LK_CMP: begin
                if (st.hash_match) begin
                    cmd        = ctt_pkg::CMD_LK_HIT;
                    state_next = S_DONE;
                end else begin
                    cmd        = ctt_pkg::CMD_LK_NEXT;
                    state_next = S_LK_RD;
                end
            end
            S_TK_RD: begin
                if (st.tk_valid) begin
                    cmd        = ctt_pkg::CMD_TK_RD;
                    state_next = S_TK_UPD;
                end else begin
                    state_next = S_TK_NEXT;
                end
            end
            S_TK_UPD: begin
                cmd        = ctt_pkg::CMD_TK_UPD;
                state_next = st.tk_expire ? S_UL_HEAD : S_TK_NEXT;
            end
            S_TK_NEXT: begin
                if (st.tk_last) begin
                    state_next = S_DONE;
                end else begin
                    cmd        = ctt_pkg::CMD_TK_INC;
                    state_next = S_TK_RD;
                end
            end
            S_UL_HEAD: begin
                cmd        = ctt_pkg::CMD_UL_HEAD;
                state_next = S_UL_SET;
            end
            S_UL_SET: begin
                cmd        = ctt_pkg::CMD_UL_SET;
                state_next = S_UL_RD;
            end
            S_UL_RD: begin
                if (st.cur_nil) begin
                    cmd        = ctt_pkg::CMD_UL_DROP;
                    state_next = S_TK_NEXT;
                end else begin
                    cmd        = ctt_pkg::CMD_UL_RD;
                    state_next = S_UL_CMP;
                end
            end
            S_UL_CMP: begin
                if (st.cur_is_vic) begin
                    cmd        = ctt_pkg::CMD_UL_LINK;
                    state_next = S_TK_NEXT;
                end else begin
                    cmd        = ctt_pkg::CMD_UL_STEP;
                    state_next = S_UL_RD;
                end
            end
            S_DONE: begin
                if (st.out_free) begin
                    cmd        = ctt_pkg::CMD_OUT_LOAD;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

@@ sv/ctt_dpath.sv @@
module ctt_dpath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctt_pkg::ctt_cmd_t    cmd,
    output ctt_pkg::ctt_status_t st,
    input  ctt_pkg::in_item_t    s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ctt_pkg::out_item_t   m_item,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_wdata
);

    localparam int IW = ctt_pkg::IDX_W;
    localparam int PW = ctt_pkg::PTR_W;
    localparam int AW = ctt_pkg::HEAD_AW;

    // Memories.
    logic [PW-1:0]     head_mem [ctt_pkg::HEADS];
    ctt_pkg::ent_t     ent_mem  [ctt_pkg::ENTRIES];
    logic [PW-1:0]     head_q;
    ctt_pkg::ent_t     ent_q;

    // Control registers.
    logic [ctt_pkg::ENTRIES-1:0] valid_reg;
    logic [8:0]        cnt_reg [3];
    logic [8:0]        limit_reg [3];
    logic [15:0]       start_reg [3];
    logic [15:0]       cap_reg [2];
    logic [AW-1:0]     clr_reg;
    logic              m_valid_reg;

    // Working registers.
    ctt_pkg::in_item_t  item_reg;
    ctt_pkg::out_item_t res_reg;
    ctt_pkg::out_item_t m_item_reg;
    logic [PW-1:0]      cur_reg;
    logic [PW-1:0]      prev_reg;
    ctt_pkg::ent_t      prev_rec_reg;
    logic [IW-1:0]      scan_reg;
    logic [IW-1:0]      idx_reg;
    logic [1:0]         vic_proto_reg;
    logic [ctt_pkg::HASH_BITS-1:0] vic_hash_reg;

    logic [ctt_pkg::HASH_BITS-1:0] item_hash;
    logic [AW-1:0]     item_bucket;
    logic [AW-1:0]     vic_bucket;
    logic [AW-1:0]     head_raddr;
    logic [AW-1:0]     head_waddr;
    logic [PW-1:0]     head_wdata;
    logic              head_we;
    logic [IW-1:0]     ent_raddr;
    logic [IW-1:0]     ent_waddr;
    ctt_pkg::ent_t     ent_wdata;
    logic              ent_we;
    logic [15:0]       idle_inc;
    logic [3:0]        tcp_res;
    logic [15:0]       cap_sel;
    logic [15:0]       timeout_grown;
    ctt_pkg::ent_t     hit_rec;
    logic [8:0]        cnt_sel;
    logic [8:0]        limit_sel;
    logic              out_free;

    assign item_hash   = item_reg.conn_hash[ctt_pkg::HASH_BITS-1:0];
    assign item_bucket = ctt_pkg::bucket_of(item_reg.proto, item_hash);
    assign vic_bucket  = ctt_pkg::bucket_of(vic_proto_reg, vic_hash_reg);
    assign out_free    = !m_valid_reg || m_ready;

    // Count and limit of the request's protocol.
    always_comb begin
        case (item_reg.proto)
            ctt_pkg::PROTO_TCP: begin
                cnt_sel   = cnt_reg[0];
                limit_sel = limit_reg[0];
            end
            ctt_pkg::PROTO_UDP: begin
                cnt_sel   = cnt_reg[1];
                limit_sel = limit_reg[1];
            end
            ctt_pkg::PROTO_ICMP: begin
                cnt_sel   = cnt_reg[2];
                limit_sel = limit_reg[2];
            end
            default: begin
                cnt_sel   = '0;
                limit_sel = '0;
            end
        endcase
    end

    // Updated entry on a lookup hit.
    always_comb begin
        tcp_res = ctt_pkg::tcp_advance(ent_q.tstate, item_reg.tcp_flags);
        cap_sel = (item_reg.proto == ctt_pkg::PROTO_TCP) ? cap_reg[0] : cap_reg[1];
        timeout_grown = ent_q.timeout;
        if (item_reg.proto != ctt_pkg::PROTO_ICMP && cap_sel != 16'd0
                && ent_q.timeout < cap_sel) begin
            timeout_grown = ent_q.timeout + 16'd1;
        end
        hit_rec         = ent_q;
        hit_rec.idle    = 16'd0;
        hit_rec.timeout = timeout_grown;
        if (item_reg.proto == ctt_pkg::PROTO_TCP) begin
            hit_rec.tstate = tcp_res[2:0];
        end
    end

    assign idle_inc = (ent_q.idle == 16'hFFFF) ? ent_q.idle : ent_q.idle + 16'd1;

    // Status to the controller.
    always_comb begin
        st.act        = item_reg.action;
        st.proto_bad  = (item_reg.proto == 2'd3);
        st.limit_hit  = (cnt_sel >= limit_sel);
        st.scan_free  = !valid_reg[scan_reg];
        st.scan_last  = (scan_reg == IW'(ctt_pkg::ENTRIES - 1));
        st.cur_nil    = (cur_reg == ctt_pkg::NIL);
        st.hash_match = (ent_q.hash == item_hash);
        st.tk_valid   = valid_reg[idx_reg];
        st.tk_expire  = (idle_inc >= ent_q.timeout);
        st.tk_last    = (idx_reg == IW'(ctt_pkg::ENTRIES - 1));
        st.cur_is_vic = (cur_reg == {1'b0, idx_reg});
        st.clr_last   = (clr_reg == AW'(ctt_pkg::HEADS - 1));
        st.out_free   = out_free;
    end

    // Memory address and write selection.
    always_comb begin
        head_raddr = (cmd == ctt_pkg::CMD_UL_HEAD) ? vic_bucket : item_bucket;
        ent_raddr  = (cmd == ctt_pkg::CMD_TK_RD) ? idx_reg : cur_reg[IW-1:0];
        head_we    = 1'b0;
        head_waddr = item_bucket;
        head_wdata = {1'b0, scan_reg};
        ent_we     = 1'b0;
        ent_waddr  = cur_reg[IW-1:0];
        ent_wdata  = hit_rec;
        case (cmd)
            ctt_pkg::CMD_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                head_wdata = ctt_pkg::NIL;
            end
            ctt_pkg::CMD_LK_HIT: begin
                ent_we = 1'b1;
            end
            ctt_pkg::CMD_AD_WR: begin
                head_we           = 1'b1;
                ent_we            = 1'b1;
                ent_waddr         = scan_reg;
                ent_wdata.nxt     = head_q;
                ent_wdata.proto   = item_reg.proto;
                ent_wdata.hash    = item_hash;
                ent_wdata.tstate  = ctt_pkg::TS_SYN;
                ent_wdata.idle    = 16'd0;
                case (item_reg.proto)
                    ctt_pkg::PROTO_TCP: ent_wdata.timeout = start_reg[0];
                    ctt_pkg::PROTO_UDP: ent_wdata.timeout = start_reg[1];
                    default:            ent_wdata.timeout = start_reg[2];
                endcase
            end
            ctt_pkg::CMD_TK_UPD: begin
                ent_we         = 1'b1;
                ent_waddr      = idx_reg;
                ent_wdata      = ent_q;
                ent_wdata.idle = idle_inc;
            end
            ctt_pkg::CMD_UL_LINK: begin
                if (prev_reg == ctt_pkg::NIL) begin
                    head_we    = 1'b1;
                    head_waddr = vic_bucket;
                    head_wdata = ent_q.nxt;
                end else begin
                    ent_we        = 1'b1;
                    ent_waddr     = prev_reg[IW-1:0];
                    ent_wdata     = prev_rec_reg;
                    ent_wdata.nxt = ent_q.nxt;
                end
            end
            default: begin
            end
        endcase
    end

    // Head memory.
    always_ff @(posedge aclk) begin
        if (head_we) head_mem[head_waddr] <= head_wdata;
        head_q <= head_mem[head_raddr];
    end

    // Entry memory.
    always_ff @(posedge aclk) begin
        if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
        ent_q <= ent_mem[ent_raddr];
    end

    // Control state: valid bits, counts, configuration, output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            cnt_reg[0]   <= '0;
            cnt_reg[1]   <= '0;
            cnt_reg[2]   <= '0;
            limit_reg[0] <= 9'd256;
            limit_reg[1] <= 9'd256;
            limit_reg[2] <= 9'd256;
            start_reg[0] <= 16'd10;
            start_reg[1] <= 16'd10;
            start_reg[2] <= 16'd10;
            cap_reg[0]   <= 16'd0;
            cap_reg[1]   <= 16'd0;
            clr_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd == ctt_pkg::CMD_CLEAR) clr_reg <= clr_reg + AW'(1);
            if (cmd == ctt_pkg::CMD_AD_WR) begin
                valid_reg[scan_reg] <= 1'b1;
                case (item_reg.proto)
                    ctt_pkg::PROTO_TCP: cnt_reg[0] <= cnt_reg[0] + 9'd1;
                    ctt_pkg::PROTO_UDP: cnt_reg[1] <= cnt_reg[1] + 9'd1;
                    default:            cnt_reg[2] <= cnt_reg[2] + 9'd1;
                endcase
            end
            if (cmd == ctt_pkg::CMD_UL_LINK || cmd == ctt_pkg::CMD_UL_DROP) begin
                valid_reg[idx_reg] <= 1'b0;
                case (vic_proto_reg)
                    ctt_pkg::PROTO_TCP: begin
                        if (cnt_reg[0] != 9'd0) cnt_reg[0] <= cnt_reg[0] - 9'd1;
                    end
                    ctt_pkg::PROTO_UDP: begin
                        if (cnt_reg[1] != 9'd0) cnt_reg[1] <= cnt_reg[1] - 9'd1;
                    end
                    ctt_pkg::PROTO_ICMP: begin
                        if (cnt_reg[2] != 9'd0) cnt_reg[2] <= cnt_reg[2] - 9'd1;
                    end
                    default: begin
                    end
                endcase
            end
            if (cfg_we) begin
                case (cfg_index)
                    ctt_pkg::REG_TCP_LIMIT:  limit_reg[0] <= cfg_wdata[8:0];
                    ctt_pkg::REG_UDP_LIMIT:  limit_reg[1] <= cfg_wdata[8:0];
                    ctt_pkg::REG_ICMP_LIMIT: limit_reg[2] <= cfg_wdata[8:0];
                    ctt_pkg::REG_TCP_START:  start_reg[0] <= cfg_wdata;
                    ctt_pkg::REG_UDP_START:  start_reg[1] <= cfg_wdata;
                    ctt_pkg::REG_ICMP_START: start_reg[2] <= cfg_wdata;
                    ctt_pkg::REG_TCP_CAP:    cap_reg[0]   <= cfg_wdata;
                    ctt_pkg::REG_UDP_CAP:    cap_reg[1]   <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (cmd == ctt_pkg::CMD_OUT_LOAD) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the request in flight.
    always_ff @(posedge aclk) begin
        case (cmd)
            ctt_pkg::CMD_ACCEPT: begin
                item_reg <= s_item;
                res_reg  <= '0;
                scan_reg <= '0;
                idx_reg  <= '0;
            end
            ctt_pkg::CMD_SET_FULL: begin
                res_reg.table_full <= 1'b1;
            end
            ctt_pkg::CMD_AD_INC: begin
                scan_reg <= scan_reg + IW'(1);
            end
            ctt_pkg::CMD_AD_WR: begin
                res_reg.added <= 1'b1;
            end
            ctt_pkg::CMD_LK_SETCUR: begin
                cur_reg <= head_q;
            end
            ctt_pkg::CMD_LK_NEXT: begin
                cur_reg <= ent_q.nxt;
            end
            ctt_pkg::CMD_LK_HIT: begin
                res_reg.found <= 1'b1;
                if (item_reg.proto == ctt_pkg::PROTO_TCP) begin
                    res_reg.allowed       <= tcp_res[3];
                    res_reg.tcp_state_out <= tcp_res[2:0];
                end else begin
                    res_reg.allowed <= 1'b1;
                end
            end
            ctt_pkg::CMD_TK_UPD: begin
                vic_proto_reg <= ent_q.proto;
                vic_hash_reg  <= ent_q.hash;
                if (idle_inc >= ent_q.timeout && res_reg.expired_count != 9'd511) begin
                    res_reg.expired_count <= res_reg.expired_count + 9'd1;
                end
            end
            ctt_pkg::CMD_TK_INC: begin
                idx_reg <= idx_reg + IW'(1);
            end
            ctt_pkg::CMD_UL_SET: begin
                cur_reg  <= head_q;
                prev_reg <= ctt_pkg::NIL;
            end
            ctt_pkg::CMD_UL_STEP: begin
                prev_reg     <= cur_reg;
                prev_rec_reg <= ent_q;
                cur_reg      <= ent_q.nxt;
            end
            ctt_pkg::CMD_OUT_LOAD: begin
                m_item_reg <= res_reg;
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

`ifndef SYNTH
    // A new entry only ever lands in a free slot.
    a_add_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == ctt_pkg::CMD_AD_WR |-> !valid_reg[scan_reg])
        else $error("add writes an occupied slot");

    // Only a live entry is removed.
    a_remove_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == ctt_pkg::CMD_UL_LINK || cmd == ctt_pkg::CMD_UL_DROP) |-> valid_reg[idx_reg])
        else $error("removal of a free slot");

    // The per-protocol counts add up to the number of live entries.
    a_count_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(cnt_reg[0]) + 32'(cnt_reg[1]) + 32'(cnt_reg[2])) == 32'($countones(valid_reg)))
        else $error("protocol counts disagree with valid bits");

    // A result is loaded only when the output register is free.
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == ctt_pkg::CMD_OUT_LOAD |-> out_free)
        else $error("result overwritten");
`endif

endmodule

@@ tb/tb_connection_tracking_table.sv @@
`timescale 1ns / 100ps

// Keeps the expected table results in arrival order and checks the block's results.
class conn_result_board;
    ctt_pkg::out_item_t pending[$];
    int                 errors;

    function new();
        pending = {};
        errors  = 0;
    endfunction

    function void note_request(input ctt_pkg::out_item_t exp_item);
        pending.push_back(exp_item);
    endfunction

    function void check_result(input ctt_pkg::out_item_t got);
        ctt_pkg::out_item_t exp_item;
        if (pending.size() == 0) begin
            $error("unexpected result %h", got);
            errors++;
            return;
        end
        exp_item = pending.pop_front();
        if (got.found !== exp_item.found) begin
            $error("found exp %0d got %0d", exp_item.found, got.found);
            errors++;
        end
        if (got.tcp_state_out !== exp_item.tcp_state_out) begin
            $error("tcp_state_out exp %0d got %0d", exp_item.tcp_state_out, got.tcp_state_out);
            errors++;
        end
        if (got.allowed !== exp_item.allowed) begin
            $error("allowed exp %0d got %0d", exp_item.allowed, got.allowed);
            errors++;
        end
        if (got.added !== exp_item.added) begin
            $error("added exp %0d got %0d", exp_item.added, got.added);
            errors++;
        end
        if (got.table_full !== exp_item.table_full) begin
            $error("table_full exp %0d got %0d", exp_item.table_full, got.table_full);
            errors++;
        end
        if (got.expired_count !== exp_item.expired_count) begin
            $error("expired_count exp %0d got %0d", exp_item.expired_count, got.expired_count);
            errors++;
        end
    endfunction
endclass

module tb_connection_tracking_table;

    localparam int NBKT      = 1 << ctt_pkg::BUCKET_BITS;
    localparam int NENT      = ctt_pkg::ENTRIES;
    localparam int STALL_MAX = 200000;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    ctt_pkg::in_item_t  s_item;
    logic               m_valid;
    logic               m_ready;
    ctt_pkg::out_item_t m_item;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_wdata;

    connection_tracking_table u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the connection table.
    logic [15:0]         regs_q [8];
    int                  head_q [3*NBKT];
    int                  next_q [NENT];
    bit                  live_q [NENT];
    logic [1:0]          eproto_q [NENT];
    logic [63:0]         ehash_q [NENT];
    logic [2:0]          estate_q [NENT];
    int                  etmo_q [NENT];
    int                  eidle_q [NENT];
    int                  pcount_q [3];

    conn_result_board board;
    logic [63:0]      known_hashes[$];
    bit               rx_hold;
    int               idle_cycles;
    bit               done_flag;

    // Free-running clock.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int bucket_index(input logic [1:0] p, input logic [63:0] h);
        return int'(p) * NBKT + int'(h[63 -: ctt_pkg::BUCKET_BITS]);
    endfunction

    function automatic void table_reset();
        regs_q[ctt_pkg::REG_TCP_LIMIT]  = 256;
        regs_q[ctt_pkg::REG_UDP_LIMIT]  = 256;
        regs_q[ctt_pkg::REG_ICMP_LIMIT] = 256;
        regs_q[ctt_pkg::REG_TCP_START]  = 10;
        regs_q[ctt_pkg::REG_UDP_START]  = 10;
        regs_q[ctt_pkg::REG_ICMP_START] = 10;
        regs_q[ctt_pkg::REG_TCP_CAP]    = 0;
        regs_q[ctt_pkg::REG_UDP_CAP]    = 0;
        foreach (head_q[i]) head_q[i] = NENT;
        foreach (live_q[i]) live_q[i] = 1'b0;
        foreach (pcount_q[i]) pcount_q[i] = 0;
    endfunction

    // Flag state machine; returns whether the flags are legal and moves the state.
    function automatic bit tcp_step(inout logic [2:0] st, input logic [3:0] fl);
        bit syn;
        bit ack;
        bit fin;
        syn = fl[0];
        ack = fl[1];
        fin = fl[2];
        if (fl[3]) begin
            st = ctt_pkg::TS_CLOSED;
            return 1'b1;
        end
        case (st)
            ctt_pkg::TS_SYN: begin
                if (ack && syn) begin st = ctt_pkg::TS_SYNACK; return 1'b1; end
                return syn;
            end
            ctt_pkg::TS_SYNACK: begin
                if (ack) begin st = ctt_pkg::TS_CONN; return 1'b1; end
                return 1'b0;
            end
            ctt_pkg::TS_CONN: begin
                if (fin && ack) st = ctt_pkg::TS_FIN1;
                return 1'b1;
            end
            ctt_pkg::TS_FIN1: begin
                if (ack) begin st = ctt_pkg::TS_ACK1; return 1'b1; end
                return 1'b0;
            end
            ctt_pkg::TS_ACK1: begin
                if (fin && ack) begin st = ctt_pkg::TS_FIN2; return 1'b1; end
                return ack;
            end
            ctt_pkg::TS_FIN2: begin
                if (ack) begin st = ctt_pkg::TS_CLOSED; return 1'b1; end
                return 1'b0;
            end
            ctt_pkg::TS_CLOSED: return ack;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void drop_entry(input int e);
        int b;
        int cur;
        int prev;
        b = bucket_index(eproto_q[e], ehash_q[e]);
        cur = head_q[b];
        prev = NENT;
        while (cur < NENT) begin
            if (cur == e) begin
                if (prev == NENT) head_q[b] = next_q[cur];
                else next_q[prev] = next_q[cur];
                break;
            end
            prev = cur;
            cur = next_q[cur];
        end
        live_q[e] = 1'b0;
        if (pcount_q[eproto_q[e]] > 0) pcount_q[eproto_q[e]]--;
    endfunction

    // Works out the result of one request and updates the shadow table.
    function automatic ctt_pkg::out_item_t table_predict(input ctt_pkg::in_item_t it);
        ctt_pkg::out_item_t r;
        int        cur;
        int        slot;
        int        b;
        int        n;
        logic [2:0] st;
        r = '0;
        if (it.action == ctt_pkg::ACT_LOOKUP && it.proto <= ctt_pkg::PROTO_ICMP) begin
            cur = head_q[bucket_index(it.proto, it.conn_hash)];
            while (cur < NENT && ehash_q[cur] != it.conn_hash) cur = next_q[cur];
            if (cur < NENT) begin
                r.found = 1'b1;
                if (it.proto == ctt_pkg::PROTO_TCP) begin
                    st = estate_q[cur];
                    r.allowed = tcp_step(st, it.tcp_flags);
                    estate_q[cur] = st;
                    r.tcp_state_out = st;
                end else begin
                    r.allowed = 1'b1;
                end
                eidle_q[cur] = 0;
                if (it.proto != ctt_pkg::PROTO_ICMP) begin
                    n = regs_q[ctt_pkg::REG_TCP_CAP + it.proto];
                    if (n != 0 && etmo_q[cur] < n) etmo_q[cur]++;
                end
            end
        end else if (it.action == ctt_pkg::ACT_ADD && it.proto <= ctt_pkg::PROTO_ICMP) begin
            slot = 0;
            while (slot < NENT && live_q[slot]) slot++;
            if (pcount_q[it.proto] >= regs_q[it.proto] || slot >= NENT) begin
                r.table_full = 1'b1;
            end else begin
                b = bucket_index(it.proto, it.conn_hash);
                live_q[slot]   = 1'b1;
                eproto_q[slot] = it.proto;
                ehash_q[slot]  = it.conn_hash;
                estate_q[slot] = ctt_pkg::TS_SYN;
                etmo_q[slot]   = regs_q[ctt_pkg::REG_TCP_START + it.proto];
                eidle_q[slot]  = 0;
                next_q[slot]   = head_q[b];
                head_q[b]      = slot;
                pcount_q[it.proto]++;
                r.added = 1'b1;
            end
        end else if (it.action == ctt_pkg::ACT_TICK) begin
            n = 0;
            for (int i = 0; i < NENT; i++) begin
                if (!live_q[i]) continue;
                if (eidle_q[i] < 16'hFFFF) eidle_q[i]++;
                if (eidle_q[i] >= etmo_q[i]) begin
                    drop_entry(i);
                    if (n < 511) n++;
                end
            end
            r.expired_count = 9'(n);
        end
        return r;
    endfunction

    // Short gaps mostly, now and then a long one.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    task automatic write_reg(input logic [2:0] idx, input int val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= 16'(val);
        @(negedge aclk);
        cfg_we    <= 1'b0;
        regs_q[idx] = 16'(val);
    endtask

    // Offers one request and holds it until it is taken. Valid stays high after
    // the accepting edge until the next request or an idle stretch replaces it.
    task automatic send_request(input ctt_pkg::in_item_t it, input bit with_gap);
        int g;
        g = with_gap ? pick_gap() : 0;
        @(negedge aclk);
        if (g != 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        board.note_request(table_predict(it));
        if (it.action == ctt_pkg::ACT_ADD && it.proto <= ctt_pkg::PROTO_ICMP)
            known_hashes.push_back(it.conn_hash);
        if (known_hashes.size() > 64) void'(known_hashes.pop_front());
    endtask

    task automatic send_fields(input logic [1:0] a, input logic [1:0] p,
                               input logic [63:0] h, input logic [3:0] f);
        ctt_pkg::in_item_t it;
        it.action    = a;
        it.proto     = p;
        it.conn_hash = h;
        it.tcp_flags = f;
        send_request(it, 1'b1);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (2000) @(negedge aclk);
    endtask

    // Mostly lookups of known connections, with adds, ticks and some noise.
    task automatic send_random(input int count);
        ctt_pkg::in_item_t it;
        int       k;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(99);
            it.proto     = 2'($urandom_range(2));
            it.tcp_flags = 4'($urandom);
            it.conn_hash = {$urandom, $urandom};
            if (known_hashes.size() != 0 && $urandom_range(3) != 0)
                it.conn_hash = known_hashes[$urandom_range(known_hashes.size() - 1)];
            if ($urandom_range(7) == 0)
                it.conn_hash[63 -: ctt_pkg::BUCKET_BITS] = 8'($urandom_range(3));
            if (k < 55) it.action = ctt_pkg::ACT_LOOKUP;
            else if (k < 85) it.action = ctt_pkg::ACT_ADD;
            else if (k < 95) it.action = ctt_pkg::ACT_TICK;
            else begin
                it.action = 2'($urandom);
                it.proto  = 2'($urandom);
            end
            send_request(it, 1'b1);
        end
    endtask

    // Result side: random back-pressure, with a long hold when asked for.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold) m_ready <= 1'b0;
            else m_ready <= (pick_gap() == 0) || ($urandom_range(1) == 1);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_item);
    end

    // Watchdog on cycles without any handshake.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || done_flag) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_MAX) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        int hold_len;
        board       = new();
        rx_hold     = 1'b0;
        done_flag   = 1'b0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_item      = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        table_reset();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: a TCP connection through its whole life, field extremes.
        write_reg(ctt_pkg::REG_TCP_CAP, 12);
        send_fields(ctt_pkg::ACT_ADD, ctt_pkg::PROTO_TCP, 64'hFFFF_FFFF_FFFF_FFFF, 4'h0);
        send_fields(ctt_pkg::ACT_ADD, ctt_pkg::PROTO_TCP, 64'h0, 4'h0);
        send_fields(ctt_pkg::ACT_LOOKUP, ctt_pkg::PROTO_TCP, 64'h0, 4'h0);
        send_fields(ctt_pkg::ACT_LOOKUP, ctt_pkg::PROTO_TCP, 64'h0, 4'h3);
        send_fields(ctt_pkg::ACT_LOOKUP, ctt_pkg::PROTO_TCP, 64'h0, 4'h2);
        send_fields(ctt_pkg::ACT_LOOKUP, ctt_pkg::PROTO_TCP, 64'h0, 4'h6);
        send_fields(ctt_pkg::ACT_LOOKUP, ctt_pkg::PROTO_TCP, 64'h0, 4'h1);
        send_fields(ctt_pkg::ACT_LOOKUP, ctt_pkg::PROTO_TCP, 64'h0, 4'h2);
        send_fields(ctt_pkg::ACT_LOOKUP, ctt_pkg::PROTO_TCP, 64'h0, 4'h6);
        send_fields(ctt_pkg::ACT_LOOKUP, ctt_pkg::PROTO_TCP, 64'h0, 4'h2);
        send_fields(ctt_pkg::ACT_LOOKUP, ctt_pkg::PROTO_TCP, 64'h0, 4'h0);
        send_fields(ctt_pkg::ACT_LOOKUP, ctt_pkg::PROTO_TCP, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF);
        // A duplicate add, UDP and ICMP hits, unused protocol and action.
        send_fields(ctt_pkg::ACT_ADD, ctt_pkg::PROTO_UDP, 64'h5A5A_0000_1234_5678, 4'h0);
        send_fields(ctt_pkg::ACT_ADD, ctt_pkg::PROTO_UDP, 64'h5A5A_0000_1234_5678, 4'h0);
        send_fields(ctt_pkg::ACT_LOOKUP, ctt_pkg::PROTO_UDP, 64'h5A5A_0000_1234_5678, 4'h0);
        send_fields(ctt_pkg::ACT_ADD, ctt_pkg::PROTO_ICMP, 64'h8000_0000_0000_0001, 4'h0);
        send_fields(ctt_pkg::ACT_LOOKUP, ctt_pkg::PROTO_ICMP, 64'h8000_0000_0000_0001, 4'h0);
        send_fields(ctt_pkg::ACT_LOOKUP, ctt_pkg::PROTO_ICMP, 64'h1111_2222_3333_4444, 4'h0);
        send_fields(ctt_pkg::ACT_ADD, 2'd3, 64'h1, 4'h0);
        send_fields(ctt_pkg::ACT_LOOKUP, 2'd3, 64'h1, 4'h0);
        send_fields(2'd3, ctt_pkg::PROTO_TCP, 64'h0, 4'hF);
        send_fields(ctt_pkg::ACT_TICK, ctt_pkg::PROTO_TCP, 64'h0, 4'h0);
        wait_drained();

        // Zero limits refuse every add; then start timeouts of one are written before two ticks.
        write_reg(ctt_pkg::REG_TCP_LIMIT, 0);
        write_reg(ctt_pkg::REG_UDP_LIMIT, 0);
        write_reg(ctt_pkg::REG_ICMP_LIMIT, 0);
        send_fields(ctt_pkg::ACT_ADD, ctt_pkg::PROTO_TCP, 64'h42, 4'h0);
        send_fields(ctt_pkg::ACT_ADD, ctt_pkg::PROTO_UDP, 64'h43, 4'h0);
        send_fields(ctt_pkg::ACT_ADD, ctt_pkg::PROTO_ICMP, 64'h44, 4'h0);
        wait_drained();
        write_reg(ctt_pkg::REG_TCP_LIMIT, 256);
        write_reg(ctt_pkg::REG_UDP_LIMIT, 256);
        write_reg(ctt_pkg::REG_ICMP_LIMIT, 256);
        write_reg(ctt_pkg::REG_TCP_START, 1);
        write_reg(ctt_pkg::REG_UDP_START, 1);
        write_reg(ctt_pkg::REG_ICMP_START, 1);
        send_fields(ctt_pkg::ACT_TICK, ctt_pkg::PROTO_TCP, 64'h0, 4'h0);
        send_fields(ctt_pkg::ACT_TICK, ctt_pkg::PROTO_TCP, 64'h0, 4'h0);
        wait_drained();

        // Small limits and short timeouts so that limits and expiry come often.
        write_reg(ctt_pkg::REG_TCP_LIMIT, 5);
        write_reg(ctt_pkg::REG_UDP_LIMIT, 3);
        write_reg(ctt_pkg::REG_ICMP_LIMIT, 2);
        write_reg(ctt_pkg::REG_TCP_START, 3);
        write_reg(ctt_pkg::REG_UDP_START, 2);
        write_reg(ctt_pkg::REG_ICMP_START, 4);
        write_reg(ctt_pkg::REG_TCP_CAP, 6);
        write_reg(ctt_pkg::REG_UDP_CAP, 5);
        send_random(300);

        // The receiver holds off while requests keep coming.
        rx_hold = 1'b1;
        fork
            begin
                hold_len = $urandom_range(300, 600);
                repeat (hold_len) @(posedge aclk);
                rx_hold = 1'b0;
            end
            send_random(20);
        join
        wait_drained();

        // Full table: maximum limits, long timeouts and caps at their extremes.
        write_reg(ctt_pkg::REG_TCP_LIMIT, 256);
        write_reg(ctt_pkg::REG_UDP_LIMIT, 256);
        write_reg(ctt_pkg::REG_ICMP_LIMIT, 256);
        write_reg(ctt_pkg::REG_TCP_START, 65535);
        write_reg(ctt_pkg::REG_UDP_START, 65535);
        write_reg(ctt_pkg::REG_ICMP_START, 65535);
        write_reg(ctt_pkg::REG_TCP_CAP, 65535);
        write_reg(ctt_pkg::REG_UDP_CAP, 65535);
        for (int i = 0; i < 262; i++)
            send_fields(ctt_pkg::ACT_ADD, 2'(i % 3), {$urandom, $urandom}, 4'h0);
        send_random(200);
        wait_drained();

        // Moderate settings, with ticks that leave the long-timeout entries in the table.
        write_reg(ctt_pkg::REG_TCP_START, 2);
        write_reg(ctt_pkg::REG_UDP_START, 1);
        write_reg(ctt_pkg::REG_ICMP_START, 2);
        write_reg(ctt_pkg::REG_TCP_CAP, 0);
        write_reg(ctt_pkg::REG_UDP_CAP, 0);
        repeat (3) send_fields(ctt_pkg::ACT_TICK, ctt_pkg::PROTO_TCP, 64'h0, 4'h0);
        wait_drained();
        write_reg(ctt_pkg::REG_TCP_LIMIT, 40);
        write_reg(ctt_pkg::REG_UDP_LIMIT, 30);
        write_reg(ctt_pkg::REG_ICMP_LIMIT, 20);
        write_reg(ctt_pkg::REG_TCP_START, 8);
        write_reg(ctt_pkg::REG_UDP_CAP, 20);
        send_random(300);

        // End of stimulus: wait for the last results.
        wait_drained();
        done_flag = 1'b1;
        if (board.errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
sv/ctt_pkg.sv
sv/ctt_ctrl.sv
sv/ctt_dpath.sv
sv/connection_tracking_table.sv
tb/tb_connection_tracking_table.sv
